>>> hdl/bcds_pkg.sv
// Shared constants for the binned coverage depth statistics block.
`default_nettype none
package bcds_pkg;
    localparam int BIN_SIZE_DEF = 1024;
    localparam int NUM_BINS_DEF = 262144;
    localparam int POS_W   = 28;
    localparam int OUT_W   = 23;
    localparam int DEPTH_W = 15;
    localparam int OP_W    = 2;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 15'h7fff;
    localparam logic [OUT_W-1:0]   OUT_MAX   = 23'h7fffff;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REGION = 2'd1;
    localparam logic [OP_W-1:0] OP_GLOBAL = 2'd2;
endpackage
`default_nettype wire

>>> hdl/binned_coverage_depth_statistics.sv
// Top level: per-bin depth store with add, region and global statistics.
//
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid/s_tready         s_tuser = op, s_tdata = start_req, end_req
// m_*       out  m_tvalid/m_tready         m_tdata = mean, deviation; m_tuser = empty_range
// cfg_*     in   cfg_valid/cfg_ready       cfg_data = chromosome_length
//
// After reset a clearing pass over all NUM_BINS bins zeroes the store; no item is taken then.
// BIN_SIZE is a power of two, so bin indexes and counts come from shifts.
// An add reads and then writes back each bin touched.
// A query takes two divisions, a summing pass and a deviation pass over the bins, a product
// for any out-of-store tail and a square root.
// One item is worked at a time; a finished result waits in the output register.
`default_nettype none
module binned_coverage_depth_statistics
    import bcds_pkg::*;
#(
    parameter int BIN_SIZE = BIN_SIZE_DEF,
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [55:0]       s_tdata,   // start_req[27:0], end_req[55:28]
    input  wire logic [OP_W-1:0]   s_tuser,   // op[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // mean_value[22:0], deviation_value[45:23]
    output logic                   m_tuser,   // empty_range[0]
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [POS_W-1:0]  cfg_data   // chromosome_length[27:0]
);
    localparam int AW = $clog2(NUM_BINS);
    localparam int BSH = $clog2(BIN_SIZE);
    localparam int PW = POS_W + 2;
    localparam int SW = DEPTH_W + AW + 1;
    localparam logic [PW-1:0] NB = PW'(NUM_BINS);

    localparam logic [4:0] ST_CLEAR = 5'd0,  ST_IDLE = 5'd1,  ST_DIV  = 5'd2,
                           ST_CNT   = 5'd3,
                           ST_ARD   = 5'd6,  ST_AWR  = 5'd7,  ST_SRD  = 5'd8,
                           ST_SACC  = 5'd9,  ST_MEAN = 5'd10, ST_VRD  = 5'd11,
                           ST_VSQ   = 5'd12, ST_VACC = 5'd13, ST_TAIL = 5'd14,
                           ST_TMUL  = 5'd15, ST_TADD = 5'd16, ST_DEV  = 5'd17,
                           ST_SQI   = 5'd18, ST_SQRT = 5'd19, ST_OUT  = 5'd20;

    logic [4:0]         state_reg, state_next, ret_reg, ret_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [POS_W-1:0]   d_reg, d_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [PW-1:0]      ptr_reg, ptr_next, lim_reg, lim_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [63:0]        acc_reg, acc_next;
    logic [OUT_W-1:0]   mean_reg, mean_next, dev_reg, dev_next;
    logic               empty_reg, empty_next;
    logic [45:0]        sq_reg, sq_next, mm_reg, mm_next;
    logic               skip_reg, skip_next;
    logic [POS_W-1:0]   tn_reg, tn_next;
    logic [4:0]         tb_reg, tb_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        dn_reg, dn_next;
    logic [31:0]        dr_reg, dr_next, dd_reg, dd_next;
    logic [5:0]         dc_reg, dc_next;
    logic [63:0]        qv_reg, qv_next, qr_reg, qr_next, qb_reg, qb_next;
    logic [POS_W-1:0]   len_reg;
    logic               mv_reg;
    logic [47:0]        mdata_reg;
    logic               muser_reg;
    logic               load_out;

    logic [DEPTH_W-1:0] mem [NUM_BINS];
    logic [DEPTH_W-1:0] rd_reg;
    logic               we;
    logic [DEPTH_W-1:0] wd;

    logic [POS_W-1:0]   in_s, in_e, sw_s, sw_e;
    logic [PW-1:0]      cnt_num;
    logic [32:0]        r_sh;
    logic [22:0]        xa, diff;
    logic [25:0]        x5, m2;
    logic [24:0]        x2;
    logic [25:0]        m5;
    logic [64:0]        sadd, padd;
    logic [63:0]        p2;
    logic [PW-1:0]      lo_sum, first;
    logic [64:0]        qsum;

    assign in_s = s_tdata[27:0];
    assign in_e = s_tdata[55:28];
    assign sw_s = (s_tuser == OP_REGION && in_e < in_s) ? in_e : in_s;
    assign sw_e = (s_tuser == OP_REGION && in_e < in_s) ? in_s : in_e;
    assign cnt_num = PW'(sw_e) - PW'(sw_s) + PW'(BIN_SIZE - 1);
    assign r_sh = {dr_reg, dn_reg[63]};
    assign xa = {rd_reg, 8'd0};
    assign diff = (xa >= mean_reg) ? xa - mean_reg : mean_reg - xa;
    assign x5 = 26'(xa) * 26'd5;
    assign m2 = {2'd0, mean_reg, 1'b0};
    assign x2 = {1'b0, xa, 1'b0};
    assign m5 = 26'(mean_reg) * 26'd5;
    assign sadd = {1'b0, acc_reg} + {18'd0, sq_reg};
    assign p2 = prod_reg[63] ? {64{1'b1}} : {prod_reg[62:0], 1'b0};
    assign padd = {1'b0, p2} + {19'd0, mm_reg};
    assign lo_sum = PW'(lo_reg) + PW'(d_reg);
    assign first = (PW'(lo_reg) > NB) ? PW'(lo_reg) : NB;
    assign qsum = {1'b0, qr_reg} + {1'b0, qb_reg};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;
    assign load_out  = (state_reg == ST_OUT) && (!mv_reg || m_tready);

    always_comb begin
        state_next = state_reg;  ret_next = ret_reg;   op_next = op_reg;
        d_next = d_reg;
        lo_next = lo_reg;        hi_next = hi_reg;     ptr_next = ptr_reg;
        lim_next = lim_reg;      sum_next = sum_reg;   acc_next = acc_reg;
        mean_next = mean_reg;    dev_next = dev_reg;   empty_next = empty_reg;
        sq_next = sq_reg;        mm_next = mm_reg;     skip_next = skip_reg;
        tn_next = tn_reg;        tb_next = tb_reg;     prod_next = prod_reg;
        dn_next = dn_reg;        dr_next = dr_reg;     dd_next = dd_reg;
        dc_next = dc_reg;        qv_next = qv_reg;     qr_next = qr_reg;
        qb_next = qb_reg;
        we = 1'b0;
        wd = '0;
        case (state_reg)
            ST_CLEAR: begin
                we = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == NB - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next = s_tuser;
                    empty_next = 1'b0;
                    mean_next = '0;
                    dev_next = '0;
                    if (s_tuser == OP_ADD || s_tuser == OP_REGION || s_tuser == OP_GLOBAL) begin
                        if (!(s_tuser == OP_ADD && in_s >= in_e)) begin
                            d_next = (s_tuser == OP_GLOBAL) ? (len_reg >> BSH)
                                                            : POS_W'(cnt_num >> BSH);
                            lo_next = (s_tuser == OP_GLOBAL) ? '0 : (sw_s >> BSH);
                            hi_next = sw_e >> BSH;
                            state_next = ST_CNT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (r_sh >= {1'b0, dd_reg}) begin
                    dr_next = 32'(r_sh - {1'b0, dd_reg});
                    dn_next = {dn_reg[62:0], 1'b1};
                end else begin
                    dr_next = r_sh[31:0];
                    dn_next = {dn_reg[62:0], 1'b0};
                end
                dc_next = dc_reg + 1'b1;
                if (dc_reg == 6'd63) begin
                    state_next = ret_reg;
                end
            end
            ST_CNT: begin
                if (op_reg != OP_ADD && d_reg == '0) begin
                    empty_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    ptr_next = PW'(lo_reg);
                    if (op_reg == OP_ADD) begin
                        lim_next = (lo_sum < NB) ? lo_sum : NB;
                        state_next = ST_ARD;
                    end else begin
                        if (op_reg == OP_GLOBAL) begin
                            lim_next = (PW'(d_reg) < NB) ? PW'(d_reg) : NB;
                        end else begin
                            lim_next = (PW'(hi_reg) < NB) ? PW'(hi_reg) : NB;
                        end
                        sum_next = '0;
                        state_next = ST_SRD;
                    end
                end
            end
            ST_ARD: begin
                state_next = (ptr_reg < lim_reg) ? ST_AWR : ST_IDLE;
            end
            ST_AWR: begin
                we = 1'b1;
                wd = (rd_reg < DEPTH_MAX) ? rd_reg + 1'b1 : rd_reg;
                ptr_next = ptr_reg + 1'b1;
                state_next = ST_ARD;
            end
            ST_SRD: begin
                if (ptr_reg < lim_reg) begin
                    state_next = ST_SACC;
                end else begin
                    dn_next = (64'(sum_reg) << 8) + 64'(d_reg >> 1);
                    dd_next = 32'(d_reg);
                    dr_next = '0;
                    dc_next = '0;
                    ret_next = ST_MEAN;
                    state_next = ST_DIV;
                end
            end
            ST_SACC: begin
                sum_next = sum_reg + SW'(rd_reg);
                ptr_next = ptr_reg + 1'b1;
                state_next = ST_SRD;
            end
            ST_MEAN: begin
                mean_next = (dn_reg > 64'(OUT_MAX)) ? OUT_MAX : dn_reg[OUT_W-1:0];
                ptr_next = PW'(lo_reg);
                acc_next = '0;
                state_next = ST_VRD;
            end
            ST_VRD: begin
                state_next = (ptr_reg < lim_reg) ? ST_VSQ : ST_TAIL;
            end
            ST_VSQ: begin
                sq_next = 46'(diff) * 46'(diff);
                skip_next = (op_reg == OP_GLOBAL) && ((x5 < m2) || (26'(x2) > m5));
                state_next = ST_VACC;
            end
            ST_VACC: begin
                if (!skip_reg) begin
                    acc_next = sadd[64] ? {64{1'b1}} : sadd[63:0];
                end
                ptr_next = ptr_reg + 1'b1;
                state_next = ST_VRD;
            end
            ST_TAIL: begin
                if (op_reg == OP_REGION && PW'(hi_reg) > NB && lo_reg < hi_reg) begin
                    mm_next = 46'(mean_reg) * 46'(mean_reg);
                    tn_next = POS_W'(PW'(hi_reg) - first);
                    tb_next = 5'(POS_W - 1);
                    prod_next = '0;
                    state_next = ST_TMUL;
                end else begin
                    state_next = ST_DEV;
                end
            end
            ST_TMUL: begin
                if (tn_reg[POS_W-1]) begin
                    prod_next = padd[64] ? {64{1'b1}} : padd[63:0];
                end else begin
                    prod_next = p2;
                end
                tn_next = {tn_reg[POS_W-2:0], 1'b0};
                tb_next = tb_reg - 1'b1;
                if (tb_reg == '0) begin
                    state_next = ST_TADD;
                end
            end
            ST_TADD: begin
                acc_next = ({1'b0, acc_reg} + {1'b0, prod_reg} > 65'({64{1'b1}}))
                           ? {64{1'b1}} : acc_reg + prod_reg;
                state_next = ST_DEV;
            end
            ST_DEV: begin
                dn_next = acc_reg;
                dd_next = 32'(d_reg);
                dr_next = '0;
                dc_next = '0;
                ret_next = ST_SQI;
                state_next = ST_DIV;
            end
            ST_SQI: begin
                qv_next = dn_reg;
                qr_next = '0;
                qb_next = 64'h4000_0000_0000_0000;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (65'(qv_reg) >= qsum) begin
                    qv_next = qv_reg - qsum[63:0];
                    qr_next = (qr_reg >> 1) + qb_reg;
                end else begin
                    qr_next = qr_reg >> 1;
                end
                qb_next = qb_reg >> 2;
                if (qb_reg[0]) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (qr_reg > 64'(OUT_MAX)) begin
                    dev_next = OUT_MAX;
                end else begin
                    dev_next = qr_reg[OUT_W-1:0];
                end
                if (empty_reg) begin
                    dev_next = '0;
                end
                if (!mv_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[ptr_reg[AW-1:0]] <= wd;
        end
        rd_reg <= mem[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            len_reg   <= '0;
            mv_reg    <= 1'b0;
            qr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            qr_reg    <= qr_next;
            if (cfg_valid) begin
                len_reg <= cfg_data;
            end
            if (load_out) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next;    op_reg <= op_next;
        d_reg <= d_next;        lo_reg <= lo_next;
        hi_reg <= hi_next;      lim_reg <= lim_next;    sum_reg <= sum_next;
        acc_reg <= acc_next;    mean_reg <= mean_next;  dev_reg <= dev_next;
        empty_reg <= empty_next; sq_reg <= sq_next;     mm_reg <= mm_next;
        skip_reg <= skip_next;  tn_reg <= tn_next;      tb_reg <= tb_next;
        prod_reg <= prod_next;  dn_reg <= dn_next;      dr_reg <= dr_next;
        dd_reg <= dd_next;      dc_reg <= dc_next;      qv_reg <= qv_next;
        qb_reg <= qb_next;
        if (load_out) begin
            mdata_reg <= {2'b00,
                          empty_reg ? {OUT_W{1'b0}} : dev_next,
                          empty_reg ? {OUT_W{1'b0}} : mean_reg};
            muser_reg <= empty_reg;
        end
    end
endmodule
`default_nettype wire

>>> verif/depth_stats_checker.sv
// Checker that predicts and compares the statistics results of the binned coverage depth block.
module depth_stats_checker
    import bcds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [27:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [OUT_W-1:0] mean_value;
        logic [OUT_W-1:0] deviation_value;
        logic             empty_range;
    } depth_stats_t;

    localparam int unsigned BIN = BIN_SIZE_DEF;
    localparam int unsigned BINS = NUM_BINS_DEF;
    localparam longint unsigned ALL_ONES = 64'hffff_ffff_ffff_ffff;

    logic [DEPTH_W-1:0] depth_of_bin [BINS];
    logic [POS_W-1:0]   chrom_length;
    depth_stats_t       stats_queue[$];

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        logic [64:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[64] ? ALL_ONES : t[63:0];
    endfunction

    function automatic longint unsigned mul_sat(longint unsigned a, longint unsigned b);
        if (a != 0 && b > ALL_ONES / a) return ALL_ONES;
        return a * b;
    endfunction

    function automatic longint unsigned sq_dist(longint unsigned depth, longint unsigned mean);
        longint unsigned x;
        longint unsigned diff;
        x = depth * 256;
        diff = (x >= mean) ? x - mean : mean - x;
        return diff * diff;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned clip_out(longint unsigned v);
        return (v > OUT_MAX) ? OUT_MAX : v;
    endfunction

    task automatic predict_item(logic [1:0] op, int unsigned s, int unsigned e);
        depth_stats_t     res;
        longint unsigned  d;
        longint unsigned  sum;
        longint unsigned  acc;
        longint unsigned  m;
        longint unsigned  x;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      lim;
        int unsigned      t;
        sum = 0;
        acc = 0;
        res = '0;
        if (op == OP_ADD) begin
            if (s < e) begin
                d = (e - s + BIN - 1) / BIN;
                lo = s / BIN;
                for (longint unsigned i = 0; i < d && lo + i < BINS; i++) begin
                    if (depth_of_bin[lo + i] != DEPTH_MAX)
                        depth_of_bin[lo + i] = depth_of_bin[lo + i] + 1'b1;
                end
            end
            return;
        end
        if (op != OP_REGION && op != OP_GLOBAL) return;
        if (op == OP_REGION) begin
            if (e < s) begin
                t = s;
                s = e;
                e = t;
            end
            d = (e - s + BIN - 1) / BIN;
            lo = s / BIN;
            hi = e / BIN;
        end else begin
            d = chrom_length / BIN;
            lo = 0;
            hi = d;
        end
        if (d == 0) begin
            res.empty_range = 1'b1;
            stats_queue.push_back(res);
            return;
        end
        lim = (hi < BINS) ? hi : BINS;
        for (int unsigned i = lo; i < lim; i++) sum += depth_of_bin[i];
        m = clip_out((sum * 256 + d / 2) / d);
        for (int unsigned i = lo; i < lim; i++) begin
            x = longint'(depth_of_bin[i]) * 256;
            if (op == OP_GLOBAL && (x * 5 < m * 2 || x * 2 > m * 5)) continue;
            acc = add_sat(acc, sq_dist(depth_of_bin[i], m));
        end
        if (op == OP_REGION && hi > BINS && lo < hi)
            acc = add_sat(acc, mul_sat(hi - ((lo > BINS) ? lo : BINS), m * m));
        res.mean_value = m[OUT_W-1:0];
        res.deviation_value = clip_out(floor_root(acc / d));
        stats_queue.push_back(res);
    endtask

    always @(posedge aclk) begin
        depth_stats_t exp_res;
        depth_stats_t got;
        if (!aresetn) begin
            chrom_length <= '0;
            stats_queue.delete();
            foreach (depth_of_bin[i]) depth_of_bin[i] = '0;
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) chrom_length <= cfg_data;
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[27:0], s_tdata[55:28]);
            if (m_tvalid && m_tready) begin
                got.mean_value = m_tdata[22:0];
                got.deviation_value = m_tdata[45:23];
                got.empty_range = m_tuser;
                if (stats_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction mean=%0d dev=%0d empty=%0b",
                             $time, got.mean_value, got.deviation_value, got.empty_range);
                    fail_count++;
                end else begin
                    exp_res = stats_queue.pop_front();
                    if (got.mean_value !== exp_res.mean_value) begin
                        $display("%0t: mean_value expected %0d actual %0d",
                                 $time, exp_res.mean_value, got.mean_value);
                        fail_count++;
                    end
                    if (got.deviation_value !== exp_res.deviation_value) begin
                        $display("%0t: deviation_value expected %0d actual %0d",
                                 $time, exp_res.deviation_value, got.deviation_value);
                        fail_count++;
                    end
                    if (got.empty_range !== exp_res.empty_range) begin
                        $display("%0t: empty_range expected %0b actual %0b",
                                 $time, exp_res.empty_range, got.empty_range);
                        fail_count++;
                    end
                end
            end
            pending = stats_queue.size();
        end
    end
endmodule

>>> verif/tb.sv
// Testbench top: stimulus, handshake pacing and verdict for binned_coverage_depth_statistics.
module tb;
    import bcds_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned POS_MAX = 28'hfffffff;
    localparam int IDLE_LIMIT = 8000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [27:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;

    binned_coverage_depth_statistics u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    depth_stats_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // The receiver switches between always ready, random stalls and long stalls.
    always @(negedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: begin
                m_tready = 1'b1;
            end
            1: begin
                m_tready = 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready = ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** binned_coverage_depth_statistics: FAILED **");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, int unsigned s, int unsigned e);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {e[27:0], s[27:0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic settle_then_write(logic [27:0] length);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (1000) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = length;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned s;
        int unsigned e;
        int unsigned span;
        int unsigned pick;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        op = (pick < 55) ? OP_ADD : (pick < 85) ? OP_REGION : (pick < 97) ? OP_GLOBAL : OP_UNUSED;
        span = $urandom_range(0, 16 * 1024);
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            s = $urandom_range(0, 40 * 1024);
            e = s + span;
        end else begin
            s = $urandom & POS_MAX;
            e = (s > POS_MAX - span) ? POS_MAX : s + span;
        end
        if ($urandom_range(0, 9) == 0) e = s;
        if ($urandom_range(0, 7) == 0) send_item(op, e, s);
        else send_item(op, s, e);
    endtask

    initial begin
        logic [27:0] lengths [4];
        lengths = '{28'd1023, 28'd41477, 28'd16384, 28'd65536};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        cfg_valid = 1'b0;
        cfg_data = '0;
        burst_left = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        send_item(OP_GLOBAL, 0, 0);
        send_item(OP_REGION, 5, 5);
        send_item(OP_ADD, 0, 0);
        send_item(OP_ADD, 9000, 10);
        send_item(OP_ADD, 0, 1);
        send_item(OP_ADD, 1000, 5000);
        send_item(OP_ADD, 2048, 8192);
        send_item(OP_REGION, 0, 4096);
        send_item(OP_REGION, 4096, 0);
        send_item(OP_REGION, 100, 3000);
        send_item(OP_REGION, 1, 1);
        send_item(OP_ADD, POS_MAX - 10, POS_MAX);
        send_item(OP_ADD, POS_MAX - 3000, POS_MAX);
        send_item(OP_REGION, POS_MAX - 4096, POS_MAX);
        send_item(OP_REGION, POS_MAX, POS_MAX - 2048);
        send_item(OP_REGION, POS_MAX, 0 + POS_MAX);
        send_item(OP_UNUSED, POS_MAX, POS_MAX);
        send_item(OP_UNUSED, 0, 1024);
        send_item(OP_REGION, 0, 1023);
        send_item(OP_GLOBAL, POS_MAX, 0);

        foreach (lengths[k]) begin
            settle_then_write(lengths[k]);
            send_item(OP_GLOBAL, 0, 0);
            repeat (285) send_random_item();
        end

        settle_then_write(28'(POS_MAX));
        send_item(OP_GLOBAL, 0, POS_MAX);
        settle_then_write(28'd0);
        send_item(OP_GLOBAL, 0, 0);

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (1000) @(negedge aclk);
        if (fail_count == 0) begin
            $display("** binned_coverage_depth_statistics: PASSED **");
        end else begin
            $display("** binned_coverage_depth_statistics: FAILED **");
        end
        $finish;
    end
endmodule

>>> binned_coverage_depth_statistics.f
hdl/bcds_pkg.sv
hdl/binned_coverage_depth_statistics.sv
verif/depth_stats_checker.sv
verif/tb.sv
